### hdl/p2rt_pkg.sv
// p2rt_pkg: shared constants, codes and types for the pose2 rigid transform
// holds opcodes, register indexes, cordic arctangent table and trig bundle type
// no dependencies
package p2rt_pkg;

  localparam int COORD_WIDTH_DEF = 32;
  localparam int ANGLE_WIDTH_DEF = 16;

  // angle scaled to one full turn per 2^TURN_W
  localparam int TURN_W        = 32;
  localparam int CF_W          = 32;
  localparam int Q_SHIFT       = 30;
  localparam int CORDIC_STEPS  = 30;
  localparam int CORDIC_START  = 652032874;
  localparam int ONE_Q30       = 1 << 30;

  localparam logic [1:0] OP_FWD_POINT  = 2'd0;
  localparam logic [1:0] OP_FWD_VECTOR = 2'd1;
  localparam logic [1:0] OP_INV_POINT  = 2'd2;
  localparam logic [1:0] OP_INV_VECTOR = 2'd3;

  localparam logic [1:0] REG_POS_X = 2'd0;
  localparam logic [1:0] REG_POS_Y = 2'd1;
  localparam logic [1:0] REG_YAW   = 2'd2;

  typedef struct packed {
    logic [CF_W-1:0] cos_q30;
    logic [CF_W-1:0] sin_q30;
    logic            busy;
  } p2rt_trig_t;

  function automatic logic [31:0] atan_turn(input logic [4:0] idx);
    logic [31:0] v;
    case (idx)
      5'd0:  v = 32'h20000000;
      5'd1:  v = 32'h12E4051E;
      5'd2:  v = 32'h09FB385B;
      5'd3:  v = 32'h051111D4;
      5'd4:  v = 32'h028B0D43;
      5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E;
      5'd7:  v = 32'h00517C55;
      5'd8:  v = 32'h0028BE53;
      5'd9:  v = 32'h00145F2F;
      5'd10: v = 32'h000A2F98;
      5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;
      5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2FA;
      5'd15: v = 32'h0000517D;
      5'd16: v = 32'h000028BE;
      5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A30;
      5'd19: v = 32'h00000518;
      5'd20: v = 32'h0000028C;
      5'd21: v = 32'h00000146;
      5'd22: v = 32'h000000A3;
      5'd23: v = 32'h00000051;
      5'd24: v = 32'h00000029;
      5'd25: v = 32'h00000014;
      5'd26: v = 32'h0000000A;
      5'd27: v = 32'h00000005;
      5'd28: v = 32'h00000003;
      5'd29: v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage

### hdl/p2rt_trig.sv
// p2rt_trig: iterative cordic forming cosine and sine of the heading in q2.30
// one rotation step per cycle, quarter turn applied by swap and negate
// depends on p2rt_pkg
module p2rt_trig import p2rt_pkg::*; #(
  parameter int ANGLE_WIDTH = ANGLE_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   yaw_we,
  input  logic [ANGLE_WIDTH-1:0] yaw_value,
  output p2rt_trig_t             trig
);

  localparam int CX_W  = 34;
  localparam int Z_W   = 33;
  localparam int CNT_W = 5;
  localparam logic signed [CX_W-1:0] ONE_X   = CX_W'(ONE_Q30);
  localparam logic signed [CX_W-1:0] START_X = CX_W'(CORDIC_START);
  localparam logic [CNT_W-1:0]       CNT_LAST = CNT_W'(CORDIC_STEPS - 1);

  typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DONE} state_t;

  state_t                  st_r;
  logic signed [CX_W-1:0]  x_r;
  logic signed [CX_W-1:0]  y_r;
  logic signed [Z_W-1:0]   z_r;
  logic [CNT_W-1:0]        cnt_r;
  logic [1:0]              quad_r;
  logic [CF_W-1:0]         cos_r;
  logic [CF_W-1:0]         sin_r;

  logic [TURN_W-1:0]       turn;
  logic signed [CX_W-1:0]  dx;
  logic signed [CX_W-1:0]  dy;
  logic signed [Z_W-1:0]   at;
  logic signed [CX_W-1:0]  x_nxt;
  logic signed [CX_W-1:0]  y_nxt;
  logic signed [Z_W-1:0]   z_nxt;
  logic [CF_W-1:0]         c0;
  logic [CF_W-1:0]         s0;
  logic [CF_W-1:0]         cos_nxt;
  logic [CF_W-1:0]         sin_nxt;

  assign turn = {yaw_value, {(TURN_W-ANGLE_WIDTH){1'b0}}};

  always_comb begin
    dx = y_r >>> cnt_r;
    dy = x_r >>> cnt_r;
    at = {1'b0, atan_turn(cnt_r)};
    if (!z_r[Z_W-1]) begin
      x_nxt = x_r - dx;
      y_nxt = y_r + dy;
      z_nxt = z_r - at;
    end else begin
      x_nxt = x_r + dx;
      y_nxt = y_r - dy;
      z_nxt = z_r + at;
    end
  end

  // clamp to [0, 1.0] then rotate into the quarter turn
  always_comb begin
    if (x_r[CX_W-1]) begin
      c0 = '0;
    end else if (x_r > ONE_X) begin
      c0 = CF_W'(ONE_Q30);
    end else begin
      c0 = x_r[CF_W-1:0];
    end
    if (y_r[CX_W-1]) begin
      s0 = '0;
    end else if (y_r > ONE_X) begin
      s0 = CF_W'(ONE_Q30);
    end else begin
      s0 = y_r[CF_W-1:0];
    end
    case (quad_r)
      2'd0: begin
        cos_nxt = c0;
        sin_nxt = s0;
      end
      2'd1: begin
        cos_nxt = -s0;
        sin_nxt = c0;
      end
      2'd2: begin
        cos_nxt = -c0;
        sin_nxt = -s0;
      end
      default: begin
        cos_nxt = s0;
        sin_nxt = -c0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= ST_IDLE;
      x_r    <= '0;
      y_r    <= '0;
      z_r    <= '0;
      cnt_r  <= '0;
      quad_r <= '0;
      cos_r  <= CF_W'(ONE_Q30);
      sin_r  <= '0;
    end else if (yaw_we) begin
      quad_r <= turn[TURN_W-1 -: 2];
      y_r    <= '0;
      cnt_r  <= '0;
      z_r    <= Z_W'(turn[TURN_W-3:0]);
      if (turn[TURN_W-3:0] == '0) begin
        // exact quarter turn
        x_r  <= ONE_X;
        st_r <= ST_DONE;
      end else begin
        x_r  <= START_X;
        st_r <= ST_RUN;
      end
    end else begin
      case (st_r)
        ST_RUN: begin
          x_r   <= x_nxt;
          y_r   <= y_nxt;
          z_r   <= z_nxt;
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == CNT_LAST) begin
            st_r <= ST_DONE;
          end
        end
        ST_DONE: begin
          cos_r <= cos_nxt;
          sin_r <= sin_nxt;
          st_r  <= ST_IDLE;
        end
        default: begin
          st_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign trig.cos_q30 = cos_r;
  assign trig.sin_q30 = sin_r;
  assign trig.busy    = (st_r != ST_IDLE);

  a_yaw_starts_busy: assert property (@(posedge clk) disable iff (!rst_n)
    yaw_we |=> trig.busy)
    else $error("heading write did not start the cordic");

  a_trig_range: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_IDLE) |-> ($signed(cos_r) <= ONE_Q30 && $signed(cos_r) >= -ONE_Q30 &&
                           $signed(sin_r) <= ONE_Q30 && $signed(sin_r) >= -ONE_Q30))
    else $error("cosine or sine outside unit range");

  a_first_quarter: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_IDLE && quad_r == 2'd0) |-> (!cos_r[CF_W-1] && !sin_r[CF_W-1]))
    else $error("first quarter turn gave a negative component");

endmodule

### hdl/p2rt_pipe.sv
// p2rt_pipe: five stage rotate and translate datapath with rounding and saturation
// offset, split multiply, partial sums, round, translate and clamp
// depends on p2rt_pkg
module p2rt_pipe import p2rt_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  p2rt_trig_t                    trig,
  input  logic                          cfg_busy,
  input  logic signed [COORD_WIDTH-1:0] pos_x,
  input  logic signed [COORD_WIDTH-1:0] pos_y,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    in_opcode,
  input  logic signed [COORD_WIDTH-1:0] in_x,
  input  logic signed [COORD_WIDTH-1:0] in_y,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [COORD_WIDTH-1:0] out_x,
  output logic signed [COORD_WIDTH-1:0] out_y,
  output logic                          out_overflow
);

  localparam int CW   = COORD_WIDTH;
  localparam int VW   = CW + 1;
  localparam int LO_W = VW / 2;
  localparam int HI_W = VW - LO_W;
  localparam int PH_W = HI_W + CF_W;
  localparam int PL_W = LO_W + 1 + CF_W;
  localparam int SW   = VW + CF_W + 1;
  localparam int RW   = SW - Q_SHIFT;
  localparam int OW   = RW + 1;
  localparam logic signed [SW-1:0] RND    = SW'(ONE_Q30 / 2);
  localparam logic signed [OW-1:0] SAT_HI = {{(OW-CW+1){1'b0}}, {(CW-1){1'b1}}};
  localparam logic signed [OW-1:0] SAT_LO = {{(OW-CW+1){1'b1}}, {(CW-1){1'b0}}};
  localparam logic [CW-1:0]        OUT_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic [CW-1:0]        OUT_MIN = {1'b1, {(CW-1){1'b0}}};

  logic en1, en2, en3, en4, en5;
  logic v1_r, v2_r, v3_r, v4_r, out_valid_r;
  logic accept;

  logic [VW-1:0]                vx_nxt, vy_nxt;
  logic [CF_W-1:0]              nsin;
  logic [VW-1:0]                vx1_r, vy1_r;
  logic [CF_W-1:0]              cbx1_r, cay1_r;
  logic                         addp1_r, addp2_r, addp3_r, addp4_r;

  logic signed [PH_W-1:0]       xha_nxt, xhb_nxt, yha_nxt, yhb_nxt;
  logic signed [PL_W-1:0]       xla_nxt, xlb_nxt, yla_nxt, ylb_nxt;
  logic signed [PH_W-1:0]       xha2_r, xhb2_r, yha2_r, yhb2_r;
  logic signed [PL_W-1:0]       xla2_r, xlb2_r, yla2_r, ylb2_r;

  logic signed [PH_W:0]         xh3_r, yh3_r;
  logic signed [PL_W:0]         xl3_r, yl3_r;

  logic signed [SW-1:0]         sx_sum, sy_sum;
  logic signed [RW-1:0]         rx4_r, ry4_r;

  logic signed [OW-1:0]         tx, ty;
  logic [CW-1:0]                ox_nxt, oy_nxt;
  logic                         ovx, ovy;
  logic [CW-1:0]                out_x_r, out_y_r;
  logic                         out_ovf_r;

  // backpressure: a stage loads when it is empty or its successor moves
  assign en5 = !out_valid_r || out_ready;
  assign en4 = !v4_r || en5;
  assign en3 = !v3_r || en4;
  assign en2 = !v2_r || en3;
  assign en1 = !v1_r || en2;

  assign in_ready = en1 && !trig.busy && !cfg_busy;
  assign accept   = in_valid && in_ready;

  // stage 1: offset for inverse point, coefficient selection
  always_comb begin
    vx_nxt = {in_x[CW-1], in_x};
    vy_nxt = {in_y[CW-1], in_y};
    if (in_opcode == OP_INV_POINT) begin
      vx_nxt = vx_nxt - {pos_x[CW-1], pos_x};
      vy_nxt = vy_nxt - {pos_y[CW-1], pos_y};
    end
    nsin = -trig.sin_q30;
  end

  // stage 2: split multiply, high part signed, low part unsigned
  always_comb begin
    xha_nxt = $signed(vx1_r[VW-1:LO_W]) * $signed(trig.cos_q30);
    xhb_nxt = $signed(vy1_r[VW-1:LO_W]) * $signed(cbx1_r);
    yha_nxt = $signed(vx1_r[VW-1:LO_W]) * $signed(cay1_r);
    yhb_nxt = $signed(vy1_r[VW-1:LO_W]) * $signed(trig.cos_q30);
    xla_nxt = $signed({1'b0, vx1_r[LO_W-1:0]}) * $signed(trig.cos_q30);
    xlb_nxt = $signed({1'b0, vy1_r[LO_W-1:0]}) * $signed(cbx1_r);
    yla_nxt = $signed({1'b0, vx1_r[LO_W-1:0]}) * $signed(cay1_r);
    ylb_nxt = $signed({1'b0, vy1_r[LO_W-1:0]}) * $signed(trig.cos_q30);
  end

  // stage 4: recombine, round half up, drop the q30 fraction
  always_comb begin
    sx_sum = (SW'(xh3_r) <<< LO_W) + SW'(xl3_r) + RND;
    sy_sum = (SW'(yh3_r) <<< LO_W) + SW'(yl3_r) + RND;
  end

  // stage 5: translate and saturate
  always_comb begin
    tx  = OW'(rx4_r) + (addp4_r ? OW'(pos_x) : OW'(0));
    ty  = OW'(ry4_r) + (addp4_r ? OW'(pos_y) : OW'(0));
    ovx = (tx > SAT_HI) || (tx < SAT_LO);
    ovy = (ty > SAT_HI) || (ty < SAT_LO);
    if (tx > SAT_HI) begin
      ox_nxt = OUT_MAX;
    end else if (tx < SAT_LO) begin
      ox_nxt = OUT_MIN;
    end else begin
      ox_nxt = tx[CW-1:0];
    end
    if (ty > SAT_HI) begin
      oy_nxt = OUT_MAX;
    end else if (ty < SAT_LO) begin
      oy_nxt = OUT_MIN;
    end else begin
      oy_nxt = ty[CW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (en1) begin
        v1_r <= accept;
      end
      if (en2) begin
        v2_r <= v1_r;
      end
      if (en3) begin
        v3_r <= v2_r;
      end
      if (en4) begin
        v4_r <= v3_r;
      end
      if (en5) begin
        out_valid_r <= v4_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en1 && accept) begin
      vx1_r   <= vx_nxt;
      vy1_r   <= vy_nxt;
      cbx1_r  <= in_opcode[1] ? trig.sin_q30 : nsin;
      cay1_r  <= in_opcode[1] ? nsin : trig.sin_q30;
      addp1_r <= (in_opcode == OP_FWD_POINT);
    end
    if (en2 && v1_r) begin
      xha2_r  <= xha_nxt;
      xhb2_r  <= xhb_nxt;
      yha2_r  <= yha_nxt;
      yhb2_r  <= yhb_nxt;
      xla2_r  <= xla_nxt;
      xlb2_r  <= xlb_nxt;
      yla2_r  <= yla_nxt;
      ylb2_r  <= ylb_nxt;
      addp2_r <= addp1_r;
    end
    if (en3 && v2_r) begin
      xh3_r   <= (PH_W+1)'(xha2_r) + (PH_W+1)'(xhb2_r);
      yh3_r   <= (PH_W+1)'(yha2_r) + (PH_W+1)'(yhb2_r);
      xl3_r   <= (PL_W+1)'(xla2_r) + (PL_W+1)'(xlb2_r);
      yl3_r   <= (PL_W+1)'(yla2_r) + (PL_W+1)'(ylb2_r);
      addp3_r <= addp2_r;
    end
    if (en4 && v3_r) begin
      rx4_r   <= sx_sum[SW-1:Q_SHIFT];
      ry4_r   <= sy_sum[SW-1:Q_SHIFT];
      addp4_r <= addp3_r;
    end
    if (en5 && v4_r) begin
      out_x_r   <= ox_nxt;
      out_y_r   <= oy_nxt;
      out_ovf_r <= ovx || ovy;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_x        = out_x_r;
  assign out_y        = out_y_r;
  assign out_overflow = out_ovf_r;

  a_hold_while_trig: assert property (@(posedge clk) disable iff (!rst_n)
    (trig.busy || cfg_busy) |-> !in_ready)
    else $error("item accepted while heading terms were not settled");

  a_ovf_saturates: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_ovf_r) |-> (out_x_r == OUT_MAX || out_x_r == OUT_MIN ||
                                      out_y_r == OUT_MAX || out_y_r == OUT_MIN))
    else $error("overflow flagged without a clamped coordinate");

  a_out_from_stage4: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(v4_r))
    else $error("result appeared without an item in the last stage");

endmodule

### hdl/pose2_rigid_transform_core.sv
// pose2_rigid_transform_core: top level, pose registers, trig unit and datapath
// depends on p2rt_pkg, p2rt_trig, p2rt_pipe
//
// applies the stored planar pose to a stream of q16.16 points or vectors, one
// item per cycle while results are taken and no register write or cordic run
// holds the input, through a five register pipeline (offset, split multiply,
// partial sums, round, translate and clamp); empty stages keep filling while
// a finished result waits; a write of the yaw register starts the cordic,
// which takes one rotation step per cycle, so in_ready stays low from the
// write cycle until the cordic has loaded its result (an exact quarter turn
// skips the steps); in_ready is also low in any cycle with a register write
module pose2_rigid_transform_core import p2rt_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int ANGLE_WIDTH = ANGLE_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [1:0]                    cfg_index,
  input  logic [((COORD_WIDTH > ANGLE_WIDTH) ? COORD_WIDTH : ANGLE_WIDTH)-1:0] cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    in_opcode,
  input  logic signed [COORD_WIDTH-1:0] in_x,
  input  logic signed [COORD_WIDTH-1:0] in_y,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [COORD_WIDTH-1:0] out_x,
  output logic signed [COORD_WIDTH-1:0] out_y,
  output logic                          out_overflow
);

  logic signed [COORD_WIDTH-1:0] pos_x_r;
  logic signed [COORD_WIDTH-1:0] pos_y_r;
  logic                          yaw_we;
  p2rt_trig_t                    trig;

  assign yaw_we = cfg_we && (cfg_index == REG_YAW);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_x_r <= '0;
      pos_y_r <= '0;
    end else if (cfg_we) begin
      if (cfg_index == REG_POS_X) begin
        pos_x_r <= cfg_wdata[COORD_WIDTH-1:0];
      end
      if (cfg_index == REG_POS_Y) begin
        pos_y_r <= cfg_wdata[COORD_WIDTH-1:0];
      end
    end
  end

  p2rt_trig #(
    .ANGLE_WIDTH (ANGLE_WIDTH)
  ) u_trig (
    .clk       (clk),
    .rst_n     (rst_n),
    .yaw_we    (yaw_we),
    .yaw_value (cfg_wdata[ANGLE_WIDTH-1:0]),
    .trig      (trig)
  );

  p2rt_pipe #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_pipe (
    .clk          (clk),
    .rst_n        (rst_n),
    .trig         (trig),
    .cfg_busy     (cfg_we),
    .pos_x        (pos_x_r),
    .pos_y        (pos_y_r),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_opcode    (in_opcode),
    .in_x         (in_x),
    .in_y         (in_y),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_x        (out_x),
    .out_y        (out_y),
    .out_overflow (out_overflow)
  );

endmodule

### dv/tb_pose2_rigid_transform_core.sv
// tb_pose2_rigid_transform_core: self-checking bench for the planar pose transform core
// streams directed and random points and vectors through valid/ready under several idling mixes
// depends on p2rt_pkg and pose2_rigid_transform_core; checks against an in-bench cordic predictor
module tb_pose2_rigid_transform_core import p2rt_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CW = COORD_WIDTH_DEF;
  localparam int AW = ANGLE_WIDTH_DEF;
  localparam int CFW = (CW > AW) ? CW : AW;
  localparam int ITEMS_PER_PHASE = 168;
  localparam int RANDOM_PHASES = 8;
  localparam int HOLD_CYCLES = 300;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int MAX_REPORTS = 10;
  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam longint COORD_MAX = (longint'(1) <<< (CW - 1)) - 1;
  localparam longint COORD_MIN = -COORD_MAX - 1;
  localparam logic [CW-1:0] C_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic [CW-1:0] C_MIN = {1'b1, {(CW-1){1'b0}}};

  localparam logic [31:0] ATAN_TBL [0:29] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
  };

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

  typedef struct {
    logic [1:0]          op;
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
  } point_item_t;

  typedef struct {
    point_item_t          src;
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic                 ovf;
  } pose_result_t;

  logic                 clk;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [1:0]           cfg_index = REG_POS_X;
  logic [CFW-1:0]       cfg_wdata = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [1:0]           in_opcode = OP_FWD_POINT;
  logic signed [CW-1:0] in_x = '0;
  logic signed [CW-1:0] in_y = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic signed [CW-1:0] out_x;
  logic signed [CW-1:0] out_y;
  logic                 out_overflow;

  point_item_t  point_q[$];
  pose_result_t transformed_q[$];
  point_item_t  drive_item;
  pose_result_t want;

  longint      pose_x = 0;
  longint      pose_y = 0;
  logic [AW-1:0] yaw_reg = '0;
  longint      trig_cos = longint'(ONE_Q30);
  longint      trig_sin = 0;

  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  bit  hold_req = 1'b0;
  int  hold_left = 0;
  bit  in_took = 1'b0;
  int  quiet_cycles = 0;
  int  mismatch_count = 0;

  pose2_rigid_transform_core u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_opcode    (in_opcode),
    .in_x         (in_x),
    .in_y         (in_y),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_x        (out_x),
    .out_y        (out_y),
    .out_overflow (out_overflow)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic void heading_trig(input logic [AW-1:0] yaw, output longint c,
                                       output longint s);
    logic [31:0] turn;
    longint x, y, z, dx, dy, c0, s0;
    turn = {yaw, {(32-AW){1'b0}}};
    z = longint'(turn[29:0]);
    x = longint'(CORDIC_START);
    y = 0;
    if (z == 0) begin
      c0 = longint'(ONE_Q30);
      s0 = 0;
    end else begin
      for (int i = 0; i < 30; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (z >= 0) begin
          x = x - dx;
          y = y + dy;
          z = z - longint'(ATAN_TBL[i]);
        end else begin
          x = x + dx;
          y = y - dy;
          z = z + longint'(ATAN_TBL[i]);
        end
      end
      c0 = (x < 0) ? 0 : ((x > ONE_Q30) ? longint'(ONE_Q30) : x);
      s0 = (y < 0) ? 0 : ((y > ONE_Q30) ? longint'(ONE_Q30) : y);
    end
    case (turn[31:30])
      2'd0: begin c = c0;  s = s0;  end
      2'd1: begin c = -s0; s = c0;  end
      2'd2: begin c = -c0; s = -s0; end
      default: begin c = s0; s = -c0; end
    endcase
  endfunction

  // round half up of (a*ca + b*cb) / 2^30, exact in 96 bits
  function automatic longint round_q30(input longint a, input longint ca, input longint b,
                                       input longint cb);
    logic signed [95:0] pa, pca, pb, pcb, acc;
    pa = 96'(a);
    pca = 96'(ca);
    pb = 96'(b);
    pcb = 96'(cb);
    acc = pa * pca + pb * pcb + 96'sd536870912;
    acc = acc >>> 30;
    return longint'(acc);
  endfunction

  function automatic pose_result_t apply_pose(input point_item_t it);
    pose_result_t r;
    longint vx, vy, rx, ry, sx, sy;
    vx = longint'(it.x);
    vy = longint'(it.y);
    if (it.op == OP_INV_POINT) begin
      vx = vx - pose_x;
      vy = vy - pose_y;
    end
    if (it.op == OP_FWD_POINT || it.op == OP_FWD_VECTOR) begin
      rx = round_q30(vx, trig_cos, vy, -trig_sin);
      ry = round_q30(vx, trig_sin, vy, trig_cos);
    end else begin
      rx = round_q30(vx, trig_cos, vy, trig_sin);
      ry = round_q30(vx, -trig_sin, vy, trig_cos);
    end
    if (it.op == OP_FWD_POINT) begin
      rx = rx + pose_x;
      ry = ry + pose_y;
    end
    sx = (rx < COORD_MIN) ? COORD_MIN : ((rx > COORD_MAX) ? COORD_MAX : rx);
    sy = (ry < COORD_MIN) ? COORD_MIN : ((ry > COORD_MAX) ? COORD_MAX : ry);
    r.src = it;
    r.x = sx[CW-1:0];
    r.y = sy[CW-1:0];
    r.ovf = (sx != rx) || (sy != ry);
    return r;
  endfunction

  function automatic void flag_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS)
      $display("mismatch: %s", msg);
  endfunction

  // input driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_took) begin
      if (point_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        drive_item = point_q.pop_front();
        in_valid <= 1'b1;
        in_opcode <= drive_item.op;
        in_x <= drive_item.x;
        in_y <= drive_item.y;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result back-pressure, with one long hold-off
  always @(negedge clk) begin
    if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left = hold_left - 1;
    end else if (hold_req) begin
      hold_req = 1'b0;
      hold_left = HOLD_CYCLES - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // monitor and checker
  always @(posedge clk) begin
    if (!rst_n) begin
      in_took = 1'b0;
      quiet_cycles = 0;
    end else begin
      in_took = in_valid && in_ready;
      if (in_took)
        transformed_q.push_back(apply_pose('{op: in_opcode, x: in_x, y: in_y}));
      if (out_valid && out_ready) begin
        if (transformed_q.size() == 0) begin
          flag_mismatch($sformatf("result with none expected: x %h y %h ovf %b",
                                  out_x, out_y, out_overflow));
        end else begin
          want = transformed_q.pop_front();
          if (out_x !== want.x || out_y !== want.y || out_overflow !== want.ovf)
            flag_mismatch($sformatf(
              "op %0d in (%h,%h): exp x %h y %h ovf %b, got x %h y %h ovf %b",
              want.src.op, want.src.x, want.src.y, want.x, want.y, want.ovf,
              out_x, out_y, out_overflow));
        end
      end
      if (in_took || (out_valid && out_ready) || cfg_we)
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
  end

  initial begin
    wait (quiet_cycles >= WATCHDOG_LIMIT);
    $display("Mismatches found");
    $finish;
  end

  task automatic write_pose_reg(input logic [1:0] idx, input logic [CFW-1:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    case (idx)
      REG_POS_X: pose_x = longint'($signed(data[CW-1:0]));
      REG_POS_Y: pose_y = longint'($signed(data[CW-1:0]));
      REG_YAW: begin
        yaw_reg = data[AW-1:0];
        heading_trig(yaw_reg, trig_cos, trig_sin);
      end
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_pose(input logic [CW-1:0] px, input logic [CW-1:0] py,
                          input logic [AW-1:0] yaw);
    write_pose_reg(REG_POS_X, CFW'(px));
    write_pose_reg(REG_POS_Y, CFW'(py));
    write_pose_reg(REG_YAW, CFW'({$urandom, yaw}));
  endtask

  task automatic queue_point(input logic [1:0] op, input logic [CW-1:0] x,
                             input logic [CW-1:0] y);
    point_q.push_back('{op: op, x: x, y: y});
  endtask

  task automatic wait_drained();
    while (point_q.size() != 0 || in_valid || transformed_q.size() != 0)
      @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic set_idling(input idle_mode_t mode);
    case (mode)
      IDLE_SEND: begin send_idle_pct = 80; recv_stall_pct = 0;  end
      IDLE_RECV: begin send_idle_pct = 0;  recv_stall_pct = 80; end
      IDLE_BOTH: begin send_idle_pct = 28; recv_stall_pct = 28; end
      default:   begin send_idle_pct = 0;  recv_stall_pct = 0;  end
    endcase
  endtask

  function automatic logic [CW-1:0] rand_coord(input int span);
    logic [CW-1:0] v;
    case ($urandom_range(9))
      0: v = C_MAX;
      1: v = C_MIN;
      2: v = '0;
      3, 4: begin
        v = CW'($urandom_range(span));
        if ($urandom_range(1)) v = -v;
      end
      default: v = CW'($urandom);
    endcase
    return v;
  endfunction

  function automatic logic [AW-1:0] rand_yaw();
    logic [AW-1:0] a;
    case ($urandom_range(5))
      0: a = {2'($urandom_range(3)), {(AW-2){1'b0}}};
      1: a = '1;
      2: a = AW'(1);
      default: a = AW'($urandom);
    endcase
    return a;
  endfunction

  initial begin
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    // reset pose: identity
    queue_point(OP_FWD_POINT, C_MAX, C_MAX);
    queue_point(OP_FWD_VECTOR, C_MIN, C_MIN);
    queue_point(OP_INV_POINT, C_MIN, C_MAX);
    queue_point(OP_INV_VECTOR, 32'sd1, -32'sd1);
    wait_drained();

    // extreme position, eighth turn: saturation and rounding of tiny inputs
    set_pose(C_MAX, C_MIN, 16'h2000);
    queue_point(OP_FWD_POINT, C_MAX, C_MAX);
    queue_point(OP_FWD_POINT, '0, '0);
    queue_point(OP_FWD_VECTOR, 32'h00010000, '0);
    queue_point(OP_FWD_VECTOR, 32'sd1, '0);
    queue_point(OP_FWD_VECTOR, -32'sd1, '0);
    queue_point(OP_INV_POINT, C_MIN, C_MAX);
    queue_point(OP_INV_VECTOR, C_MIN, C_MIN);
    wait_drained();

    // opposite extremes, heading just short of a full turn, ignored index
    set_pose(C_MIN, C_MAX, 16'hFFFF);
    write_pose_reg(REG_UNUSED, CFW'($urandom));
    queue_point(OP_INV_POINT, C_MAX, C_MIN);
    queue_point(OP_FWD_POINT, C_MIN, C_MAX);
    queue_point(OP_INV_VECTOR, C_MAX, C_MAX);
    queue_point(OP_FWD_VECTOR, C_MIN, C_MIN);
    wait_drained();

    // exact quarter turns
    set_pose(32'h00030000, 32'hFFFE8000, 16'h4000);
    queue_point(OP_FWD_POINT, 32'h00012345, 32'hFFFF0001);
    queue_point(OP_INV_POINT, C_MIN, C_MIN);
    wait_drained();
    write_pose_reg(REG_YAW, 32'hABCD8000);
    queue_point(OP_FWD_VECTOR, C_MIN, 32'h00000007);
    queue_point(OP_INV_POINT, C_MAX, C_MIN);
    wait_drained();
    write_pose_reg(REG_YAW, 32'h0000C000);
    queue_point(OP_INV_VECTOR, C_MIN, C_MAX);
    queue_point(OP_FWD_POINT, 32'h7FFF0000, 32'h12345678);
    queue_point(OP_FWD_VECTOR, 32'sd1, 32'sd1);
    wait_drained();

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      set_idling(IDLE_NONE);
      set_pose(rand_coord(32'h01000000), rand_coord(32'h01000000), rand_yaw());
      if ($urandom_range(2) == 0)
        write_pose_reg(REG_UNUSED, CFW'($urandom));
      set_idling(idle_mode_t'(ph % 4));
      if (ph == 4)
        hold_req = 1'b1;
      for (int n = 0; n < ITEMS_PER_PHASE; n++)
        queue_point(2'($urandom_range(3)), rand_coord(32'h00200000),
                    rand_coord(32'h00200000));
      wait_drained();
    end

    set_idling(IDLE_NONE);
    repeat (20) @(negedge clk);
    if (mismatch_count == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

### pose2_rigid_transform_core.f
hdl/p2rt_pkg.sv
hdl/p2rt_trig.sv
hdl/p2rt_pipe.sv
hdl/pose2_rigid_transform_core.sv
dv/tb_pose2_rigid_transform_core.sv
